[rtl/blo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package blo_pkg;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 40;

    // command codes carried in the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_MID   = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_SEARCH    = 3'd4,
        CMD_SHOW      = 3'd5
    } cmd_t;

    // result status carried in the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 3'd0,
        ST_FULL  = 3'd1,
        ST_MISS  = 3'd2,
        ST_HIT   = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE,
        OP_SEARCH,
        OP_SHOW
    } op_t;

    typedef enum logic [1:0] {
        POS_FRONT,
        POS_END,
        POS_MID
    } where_t;

    typedef struct packed {
        op_t                op;
        where_t             where;
        logic [VALUE_W-1:0] value;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_SHIFT_UP,
        B_SHIFT_DOWN,
        B_SHOW,
        B_RESULT
    } state_t;

endpackage

`default_nettype wire

[rtl/blo_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module blo_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [blo_pkg::VALUE_W-1:0]  s_axis_tdata,
    input  wire logic [blo_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                              job_valid,
    input  wire logic                         job_ready,
    output blo_pkg::job_t                     job
);

    // two-entry queue of decoded jobs
    blo_pkg::job_t q_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;
    blo_pkg::job_t decoded;

    // classify the command
    always_comb
    begin
        decoded.value = s_axis_tdata;
        decoded.where = blo_pkg::POS_FRONT;
        case (blo_pkg::cmd_t'(s_axis_tuser))
            blo_pkg::CMD_INS_FRONT:
            begin
                decoded.op = blo_pkg::OP_INSERT;
            end
            blo_pkg::CMD_INS_END:
            begin
                decoded.op    = blo_pkg::OP_INSERT;
                decoded.where = blo_pkg::POS_END;
            end
            blo_pkg::CMD_INS_MID:
            begin
                decoded.op    = blo_pkg::OP_INSERT;
                decoded.where = blo_pkg::POS_MID;
            end
            blo_pkg::CMD_REMOVE: decoded.op = blo_pkg::OP_REMOVE;
            blo_pkg::CMD_SEARCH: decoded.op = blo_pkg::OP_SEARCH;
            blo_pkg::CMD_SHOW:   decoded.op = blo_pkg::OP_SHOW;
            default:             decoded.op = blo_pkg::OP_NOP;
        endcase
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign job_valid     = (count_reg != 2'd0);
    assign job           = q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

[rtl/blo_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module blo_back
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    output logic                               job_ready,
    input  wire blo_pkg::job_t                 job,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [blo_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic [blo_pkg::STATUS_W-1:0]       m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [blo_pkg::VALUE_W-1:0] mem [DEPTH];

    blo_pkg::state_t  state_reg;
    blo_pkg::state_t  state_next;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    idx_next;
    logic             tag_valid_reg;
    logic             tag_valid_next;
    logic [CW-1:0]    tag_addr_reg;
    logic [CW-1:0]    tag_addr_next;
    logic [CW-1:0]    pos_reg;
    logic [CW-1:0]    pos_next;
    logic [blo_pkg::VALUE_W-1:0] val_reg;
    logic [blo_pkg::VALUE_W-1:0] val_next;
    logic             remove_reg;
    logic             remove_next;
    blo_pkg::status_t status_reg;
    blo_pkg::status_t status_next;
    logic [blo_pkg::VALUE_W-1:0] rdata_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    blo_pkg::status_t out_status_reg;
    blo_pkg::status_t out_status_next;
    logic [blo_pkg::VALUE_W-1:0] out_value_reg;
    logic [blo_pkg::VALUE_W-1:0] out_value_next;
    logic [blo_pkg::COUNT_W-1:0] out_count_reg;
    logic [blo_pkg::COUNT_W-1:0] out_count_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [blo_pkg::VALUE_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             slot_free;
    logic             is_full;
    logic             is_empty;
    logic             hit;
    logic             more_scan;
    logic             more_up;
    logic             more_down;
    logic             show_last;
    logic [CW-1:0]    idx_plus;
    logic [CW-1:0]    idx_minus;
    logic [CW-1:0]    half;
    logic [CW-1:0]    ins_pos;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign is_full   = (fill_reg == CW'(DEPTH));
    assign is_empty  = (fill_reg == '0);
    assign hit       = tag_valid_reg && (rdata_reg == val_reg);
    assign idx_plus  = idx_reg + CW'(1);
    assign idx_minus = idx_reg - CW'(1);
    assign more_scan = (idx_reg < fill_reg);
    assign more_up   = (idx_reg > pos_reg);
    assign more_down = (idx_plus < fill_reg);
    assign show_last = (idx_plus == fill_reg);
    assign half      = fill_reg >> 1;

    // middle slot is max(1, n/2), or 0 on an empty list
    always_comb
    begin
        case (job.where)
            blo_pkg::POS_END:   ins_pos = fill_reg;
            blo_pkg::POS_MID:
            begin
                if (is_empty)
                    ins_pos = '0;
                else if (half == '0)
                    ins_pos = CW'(1);
                else
                    ins_pos = half;
            end
            default:            ins_pos = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blo_pkg::B_IDLE:
            begin
                if (job_valid)
                begin
                    case (job.op)
                        blo_pkg::OP_INSERT:
                            state_next = is_full ? blo_pkg::B_RESULT : blo_pkg::B_SHIFT_UP;
                        blo_pkg::OP_REMOVE, blo_pkg::OP_SEARCH:
                            state_next = is_empty ? blo_pkg::B_RESULT : blo_pkg::B_SCAN;
                        blo_pkg::OP_SHOW:
                            state_next = is_empty ? blo_pkg::B_RESULT : blo_pkg::B_SHOW;
                        default:
                            state_next = blo_pkg::B_RESULT;
                    endcase
                end
            end
            blo_pkg::B_SCAN:
            begin
                if (hit)
                    state_next = remove_reg ? blo_pkg::B_SHIFT_DOWN : blo_pkg::B_RESULT;
                else if (!tag_valid_reg && !more_scan)
                    state_next = blo_pkg::B_RESULT;
            end
            blo_pkg::B_SHIFT_UP:
            begin
                if (!more_up && !tag_valid_reg)
                    state_next = blo_pkg::B_RESULT;
            end
            blo_pkg::B_SHIFT_DOWN:
            begin
                if (!more_down && !tag_valid_reg)
                    state_next = blo_pkg::B_RESULT;
            end
            blo_pkg::B_SHOW:
            begin
                if (slot_free && show_last)
                    state_next = blo_pkg::B_IDLE;
            end
            blo_pkg::B_RESULT:
            begin
                if (slot_free)
                    state_next = blo_pkg::B_IDLE;
            end
            default: state_next = blo_pkg::B_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        job_ready       = 1'b0;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        tag_valid_next  = tag_valid_reg;
        tag_addr_next   = tag_addr_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        remove_next     = remove_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            blo_pkg::B_IDLE:
            begin
                job_ready      = 1'b1;
                val_next       = job.value;
                tag_valid_next = 1'b0;
                idx_next       = '0;
                status_next    = blo_pkg::ST_DONE;
                case (job.op)
                    blo_pkg::OP_INSERT:
                    begin
                        pos_next = ins_pos;
                        idx_next = fill_reg;
                        if (is_full)
                            status_next = blo_pkg::ST_FULL;
                    end
                    blo_pkg::OP_REMOVE, blo_pkg::OP_SEARCH:
                    begin
                        remove_next = (job.op == blo_pkg::OP_REMOVE);
                        if (is_empty)
                            status_next = blo_pkg::ST_MISS;
                    end
                    blo_pkg::OP_SHOW:
                    begin
                        if (is_empty)
                            status_next = blo_pkg::ST_EMPTY;
                        else
                            mem_re = job_valid;
                    end
                    default: status_next = blo_pkg::ST_DONE;
                endcase
            end
            blo_pkg::B_SCAN:
            begin
                if (hit)
                begin
                    tag_valid_next = 1'b0;
                    idx_next       = tag_addr_reg;
                    status_next    = remove_reg ? blo_pkg::ST_DONE : blo_pkg::ST_HIT;
                end
                else
                begin
                    if (more_scan)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = idx_reg[AW-1:0];
                        tag_valid_next = 1'b1;
                        tag_addr_next  = idx_reg;
                        idx_next       = idx_plus;
                    end
                    else
                    begin
                        tag_valid_next = 1'b0;
                    end
                    if (!tag_valid_reg && !more_scan)
                        status_next = blo_pkg::ST_MISS;
                end
            end
            blo_pkg::B_SHIFT_UP:
            begin
                if (tag_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_addr_reg[AW-1:0];
                    mem_wdata = rdata_reg;
                end
                if (more_up)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = idx_minus[AW-1:0];
                    tag_valid_next = 1'b1;
                    tag_addr_next  = idx_reg;
                    idx_next       = idx_minus;
                end
                else
                begin
                    tag_valid_next = 1'b0;
                    if (!tag_valid_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = pos_reg[AW-1:0];
                        mem_wdata   = val_reg;
                        fill_next   = fill_reg + CW'(1);
                        status_next = blo_pkg::ST_DONE;
                    end
                end
            end
            blo_pkg::B_SHIFT_DOWN:
            begin
                if (tag_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_addr_reg[AW-1:0];
                    mem_wdata = rdata_reg;
                end
                if (more_down)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = idx_plus[AW-1:0];
                    tag_valid_next = 1'b1;
                    tag_addr_next  = idx_reg;
                    idx_next       = idx_plus;
                end
                else
                begin
                    tag_valid_next = 1'b0;
                    if (!tag_valid_reg)
                    begin
                        fill_next   = fill_reg - CW'(1);
                        status_next = blo_pkg::ST_DONE;
                    end
                end
            end
            blo_pkg::B_SHOW:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = blo_pkg::ST_DONE;
                    out_value_next  = rdata_reg;
                    out_count_next  = 5'(fill_reg);
                    out_last_next   = show_last;
                    if (!show_last)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_plus[AW-1:0];
                        idx_next  = idx_plus;
                    end
                end
            end
            blo_pkg::B_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_value_next  = '0;
                    out_count_next  = 5'(fill_reg);
                    out_last_next   = 1'b1;
                end
            end
            default: job_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blo_pkg::B_IDLE;
            fill_reg      <= '0;
            tag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            tag_valid_reg <= tag_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        tag_addr_reg   <= tag_addr_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        remove_reg     <= remove_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_value_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/bounded_ordered_list_engine.sv]
// insert moves the entries from the insert slot onward up by one and then writes the new value,
// search scans from the front until a hit, remove scans the same way and then shifts the tail down,
// display streams the entries from the front, one entry per cycle while the output takes them
// throughput: one command at a time in the back end, set by the one-entry-per-cycle
// walk of the entry store; a two-entry command queue and the output register decouple the sides
// reset clears the entry count, the command queue and the output register
// the entry store itself is not cleared and holds no valid bits
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command side
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [blo_pkg::VALUE_W-1:0]   s_axis_tdata,   // item_value
    input  wire logic [blo_pkg::CMD_W-1:0]     s_axis_tuser,   // command
    // result side
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [blo_pkg::OUT_W-1:0]          m_axis_tdata,   // entry_value, entry_count, zero pad
    output logic [blo_pkg::STATUS_W-1:0]       m_axis_tuser,   // status
    output logic                               m_axis_tlast    // last_of_run
);

    // decoded job handed from the front queue to the back sequencer
    logic          job_valid;
    logic          job_ready;
    blo_pkg::job_t job;

    // front: takes command transfers, decodes them and queues up to two
    blo_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job)
    );

    // back: walks the entry store for scans and shifts, streams results
    blo_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // an empty-list result is a single final transfer with no entries held
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == blo_pkg::ST_EMPTY))
        |-> (m_axis_tlast && (m_axis_tdata[36:32] == 5'd0)))
    else $error("empty result not final or count nonzero");

    // only display streams several results, all of them with done status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == blo_pkg::ST_DONE))
    else $error("non-final result with status other than done");

    // the reported count never passes the list bound
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((DEPTH > 31) || (m_axis_tdata[36:32] <= 5'(DEPTH))))
    else $error("entry count above depth");

    // a refused insert happens only on a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == blo_pkg::ST_FULL))
        |-> ((DEPTH > 31) || (m_axis_tdata[36:32] == 5'(DEPTH))))
    else $error("insert refused on a list that is not full");

endmodule

`default_nettype wire

[tb/sv/tb_bounded_ordered_list_engine.sv]
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine;
    import blo_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 198;
    localparam int CHURN_CHUNK  = 25;
    // longest walk is a full scan plus tail shift, with margin
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

    // command codes the block has no operation for
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {
        MODE_GROW,
        MODE_MIXED,
        MODE_SHRINK
    } churn_mode_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } list_result_t;

    // tracks the list contents and the results each command should produce
    class list_scoreboard;
        logic [VALUE_W-1:0] entries[$];
        list_result_t       pending[$];
        int                 errors;
        int                 results_checked;
        int                 refused_inserts;
        int                 peak_fill;
        int                 commands_seen;

        task report_mismatch(string what, logic [VALUE_W-1:0] got,
                             logic [VALUE_W-1:0] want);
            errors++;
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        function void expect_result(status_t status, logic [VALUE_W-1:0] value, logic last);
            list_result_t r;
            r.status = status;
            r.value  = value;
            r.count  = COUNT_W'(entries.size());
            r.last   = last;
            pending.push_back(r);
        endfunction

        function int find_entry(logic [VALUE_W-1:0] value);
            int idx;
            idx = -1;
            foreach (entries[i])
                if (idx < 0 && entries[i] == value)
                    idx = i;
            return idx;
        endfunction

        // called once per accepted command transfer
        function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
            int n;
            int pos;
            int hit;
            n   = entries.size();
            hit = find_entry(value);
            commands_seen++;
            case (cmd)
                CMD_INS_FRONT, CMD_INS_END, CMD_INS_MID:
                begin
                    if (n >= DEPTH)
                    begin
                        refused_inserts++;
                        expect_result(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (cmd == CMD_INS_FRONT)
                            pos = 0;
                        else if (cmd == CMD_INS_END)
                            pos = n;
                        else
                            pos = (n == 0) ? 0 : ((n / 2 < 1) ? 1 : n / 2);
                        entries.insert(pos, value);
                        if (entries.size() > peak_fill)
                            peak_fill = entries.size();
                        expect_result(ST_DONE, '0, 1'b1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit < 0)
                        expect_result(ST_MISS, '0, 1'b1);
                    else
                    begin
                        entries.delete(hit);
                        expect_result(ST_DONE, '0, 1'b1);
                    end
                end
                CMD_SEARCH:
                    expect_result((hit >= 0) ? ST_HIT : ST_MISS, '0, 1'b1);
                CMD_SHOW:
                begin
                    if (n == 0)
                        expect_result(ST_EMPTY, '0, 1'b1);
                    else
                        foreach (entries[i])
                            expect_result(ST_DONE, entries[i], (i == n - 1));
                end
                default:
                    expect_result(ST_DONE, '0, 1'b1);
            endcase
        endfunction

        // called once per accepted result transfer
        task check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                          logic [COUNT_W-1:0] count, logic [2:0] pad, logic last);
            list_result_t want;
            results_checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", value, '0);
                return;
            end
            want = pending.pop_front();
            if (status !== want.status)
                report_mismatch("status", VALUE_W'(status), VALUE_W'(want.status));
            if (value !== want.value)
                report_mismatch("entry value", value, want.value);
            if (count !== want.count)
                report_mismatch("entry count", VALUE_W'(count), VALUE_W'(want.count));
            if (pad !== 3'b000)
                report_mismatch("tdata pad bits", VALUE_W'(pad), '0);
            if (last !== want.last)
                report_mismatch("tlast", VALUE_W'(last), VALUE_W'(want.last));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [VALUE_W-1:0]   s_axis_tdata;     // item_value
    logic [CMD_W-1:0]     s_axis_tuser;     // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;     // entry_value, entry_count, zero pad
    logic [STATUS_W-1:0]  m_axis_tuser;     // status
    logic                 m_axis_tlast;     // last_of_run

    list_scoreboard       sb;
    logic                 calm = 1'b0;      // no idling on either side while set
    int                   cycle_count = 0;

    bounded_ordered_list_engine #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, sb.pending.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check every transfer, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[VALUE_W-1:0],
                                m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W],
                                m_axis_tdata[OUT_W-1:VALUE_W+COUNT_W], m_axis_tlast);
            m_axis_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
        while (!calm && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(cmd, value);
    endtask

    function automatic logic [CMD_W-1:0] pick_insert();
        case ($urandom_range(2))
            0:       return CMD_INS_FRONT;
            1:       return CMD_INS_END;
            default: return CMD_INS_MID;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(churn_mode_t mode);
        int roll;
        int ins_pct;
        int rem_pct;
        int srch_pct;
        roll = $urandom_range(99);
        // occasional unused codes as noise
        if (roll < 2)
            return ($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        case (mode)
            MODE_GROW:   begin ins_pct = 72; rem_pct = 82; srch_pct = 92; end
            MODE_SHRINK: begin ins_pct = 15; rem_pct = 70; srch_pct = 90; end
            default:     begin ins_pct = 40; rem_pct = 65; srch_pct = 88; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct)
            return pick_insert();
        else if (roll < rem_pct)
            return CMD_REMOVE;
        else if (roll < srch_pct)
            return CMD_SEARCH;
        return CMD_SHOW;
    endfunction

    // favor values already held so removes and searches hit, and duplicates form
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40 && sb.entries.size() > 0)
            return sb.entries[$urandom_range(sb.entries.size() - 1)];
        if (roll < 60)
            return VALUE_W'($urandom_range(8)) - VALUE_W'(4);
        if (roll < 70)
        begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        int          sent;
        churn_mode_t mode;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_INS_FRONT;
        m_axis_tready = 1'b0;
        sb = new;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        send_command(CMD_SHOW, 32'h1234_5678);
        send_command(CMD_SEARCH, 32'h0000_0000);
        send_command(CMD_REMOVE, 32'h0000_0000);
        // middle insert into empty list, then with one entry
        send_command(CMD_INS_MID, 32'h7fff_ffff);
        send_command(CMD_INS_MID, 32'h8000_0000);
        send_command(CMD_INS_FRONT, 32'h0000_0000);
        send_command(CMD_INS_END, 32'hffff_ffff);
        send_command(CMD_INS_MID, 32'h5a5a_5a5a);
        send_command(CMD_INS_MID, 32'ha5a5_a5a5);
        send_command(CMD_INS_END, 32'h7fff_ffff);
        send_command(CMD_SHOW, 32'h0000_0000);
        // hits and misses, first of two duplicates removed
        send_command(CMD_SEARCH, 32'h7fff_ffff);
        send_command(CMD_SEARCH, 32'h0000_3039);
        send_command(CMD_REMOVE, 32'h7fff_ffff);
        send_command(CMD_REMOVE, 32'h0000_3039);
        send_command(CMD_SHOW, 32'hffff_ffff);
        send_command(CMD_SPARE_6, 32'hdead_beef);
        send_command(CMD_SPARE_7, 32'h0000_0000);
        send_command(CMD_INS_MID, 32'h0000_0001);
        send_command(CMD_SEARCH, 32'h8000_0000);
        send_command(CMD_REMOVE, 32'h8000_0000);
        send_command(CMD_SHOW, 32'h0000_0000);

        // fill to capacity, then inserts that must be refused
        sent = 0;
        while (sb.entries.size() < DEPTH)
        begin
            send_command(pick_insert(), pick_value());
            sent++;
        end
        repeat (3)
        begin
            send_command(pick_insert(), pick_value());
            sent++;
        end
        send_command(CMD_SHOW, $urandom);
        sent++;

        // random churn in chunks that grow, shrink or mix the list
        mode = MODE_MIXED;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % CHURN_CHUNK == 0)
                mode = churn_mode_t'($urandom_range(2));
            calm <= (sent >= 90 && sent < 140);
            send_command(pick_command(mode), pick_value());
            sent++;
        end
        s_axis_tvalid <= 1'b0;
        calm          <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d result transfers, %0d refused inserts",
                 sb.commands_seen, sb.results_checked, sb.refused_inserts);
        $display("peak fill %0d of %0d entries, %0d errors", sb.peak_fill, DEPTH, sb.errors);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
